@@ rtl/crcfr_pkg.sv @@
// Package with shared types and constants for the CRC-8 checked frame receiver.
package crcfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

    localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] TRAILER_RESET = 8'h55;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 2'd1;

    // Result of one processed byte: good is set when that byte completed a valid frame.
    typedef struct packed {
        logic                      good;
        logic [BYTE_W-1:0]         color;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } frame_t;

endpackage

@@ rtl/crc8_checked_frame_receiver.sv @@
// Top level of the CRC-8 checked frame receiver.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_rx_byte
//   m_        out        m_valid / m_ready    m_target_color, m_target_x, m_target_y
//   cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// One byte is taken per cycle while s_ready is high. A result is registered after the
// transaction that carries the tail byte: the byte waits in the input register until
// the result register is free while the parser logic checks the frame, and then the
// result register loads. Reset is synchronous and active low; it clears the frame
// position, running CRC, input and result registers and restores register defaults.
// When a result waits on m_ready, one more byte can still be taken into the
// input register; further bytes stall until the result is taken.
module crc8_checked_frame_receiver #(
    parameter int unsigned FRAME_BYTES = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [crcfr_pkg::BYTE_W-1:0]            s_rx_byte,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [crcfr_pkg::BYTE_W-1:0]            m_target_color,
    output logic signed [crcfr_pkg::COORD_W-1:0]    m_target_x,
    output logic signed [crcfr_pkg::COORD_W-1:0]    m_target_y,

    input  logic                                    cfg_wr_en,
    input  logic [crcfr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [crcfr_pkg::CFG_DAT_W-1:0]         cfg_wdata
);

    logic                                 in_valid_reg;
    logic [crcfr_pkg::BYTE_W-1:0]         in_byte_reg;
    logic [crcfr_pkg::BYTE_W-1:0]         header_reg;
    logic [crcfr_pkg::BYTE_W-1:0]         trailer_reg;
    logic                                 out_free;
    logic                                 step;
    crcfr_pkg::frame_t                    frame;

    logic                                 m_valid_reg;
    logic [crcfr_pkg::BYTE_W-1:0]         color_reg;
    logic signed [crcfr_pkg::COORD_W-1:0] x_reg;
    logic signed [crcfr_pkg::COORD_W-1:0] y_reg;

    // The result register can take a new value when it is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    // The byte in the input register is processed only when its possible result fits.
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Configuration registers. Indexes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= crcfr_pkg::HEADER_RESET;
            trailer_reg <= crcfr_pkg::TRAILER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                crcfr_pkg::REG_HEADER:  header_reg  <= cfg_wdata;
                crcfr_pkg::REG_TRAILER: trailer_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: holds one accepted byte until the parser consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    crcfr_frame_parser #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .header_value  (header_reg),
        .trailer_value (trailer_reg),
        .frame         (frame)
    );

    // Result register. A bad frame or a mid-frame byte leaves it empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= step && frame.good;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step && frame.good) begin
            color_reg <= frame.color;
            x_reg     <= frame.x;
            y_reg     <= frame.y;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_target_color = color_reg;
    assign m_target_x     = x_reg;
    assign m_target_y     = y_reg;

endmodule

@@ rtl/crcfr_crc8_step.sv @@
// One byte step of the CRC-8 (poly 0x31, MSB first) as combinational logic.
module crcfr_crc8_step (
    input  logic [crcfr_pkg::BYTE_W-1:0] crc_in,
    input  logic [crcfr_pkg::BYTE_W-1:0] data_in,
    output logic [crcfr_pkg::BYTE_W-1:0] crc_out
);

    always_comb begin
        logic [crcfr_pkg::BYTE_W-1:0] c;
        c = crc_in ^ data_in;
        for (int k = 0; k < crcfr_pkg::BYTE_W; k++) begin
            if ((c & crcfr_pkg::CRC_TOP) != '0) begin
                c = (c << 1) ^ crcfr_pkg::CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        crc_out = c;
    end

endmodule

@@ rtl/crcfr_frame_parser.sv @@
// Frame position tracking, running CRC, byte store and frame check.
module crcfr_frame_parser #(
    parameter int unsigned FRAME_BYTES = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [crcfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic [crcfr_pkg::BYTE_W-1:0] header_value,
    input  logic [crcfr_pkg::BYTE_W-1:0] trailer_value,
    output crcfr_pkg::frame_t            frame
);

    localparam int unsigned POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CRC     = POS_W'(FRAME_BYTES - 2);

    logic [POS_W-1:0]                pos_reg, pos_next, pos_start;
    logic [crcfr_pkg::BYTE_W-1:0]    crc_reg, crc_next, crc_base, crc_step;
    logic [crcfr_pkg::BYTE_W-1:0]    store_reg [FRAME_BYTES];
    logic                            last_byte;

    crcfr_crc8_step u_crc (
        .crc_in  (crc_base),
        .data_in (rx_byte),
        .crc_out (crc_step)
    );

    always_comb begin
        pos_start = (rx_byte == header_value) ? '0 : pos_reg;
        crc_base  = (pos_start == '0) ? crcfr_pkg::CRC_INIT : crc_reg;
        // The CRC byte and the tail byte are not covered by the CRC.
        crc_next  = (pos_start < POS_CRC) ? crc_step : crc_base;
        last_byte = (pos_start == POS_LAST);
        pos_next  = last_byte ? '0 : pos_start + 1'b1;

        frame.good  = last_byte && (rx_byte == trailer_value)
                      && (store_reg[POS_CRC] == crc_next);
        frame.color = store_reg[1];
        frame.x     = {store_reg[3], store_reg[2]};
        frame.y     = {store_reg[5], store_reg[4]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= crcfr_pkg::CRC_INIT;
        end else if (step) begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            store_reg[pos_start] <= rx_byte;
        end
    end

endmodule

@@ rtl/crcfr_checker.sv @@
// Port-level assertion checker for the frame receiver, with its bind statement.
module crcfr_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [crcfr_pkg::BYTE_W-1:0]         m_target_color,
    input logic signed [crcfr_pkg::COORD_W-1:0] m_target_x,
    input logic signed [crcfr_pkg::COORD_W-1:0] m_target_y
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_target_color)
            && $stable(m_target_x) && $stable(m_target_y))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With no result pending, the input side is never stalled.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register empty");

endmodule

bind crc8_checked_frame_receiver crcfr_checker u_crcfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_target_color (m_target_color),
    .m_target_x     (m_target_x),
    .m_target_y     (m_target_y)
);
